/* hdl/aisenc_pkg.sv */
// Shared types, constants and character functions of the AIS type 5 sentence encoder.
package aisenc_pkg;

   // Command queue between the front and back parts.
   localparam int QueueDepth     = 4;
   localparam int QueuePtrBits   = $clog2(QueueDepth);
   localparam int QueueCountBits = $clog2(QueueDepth + 1);

   // Message layout.
   localparam logic [5:0] MsgType    = 6'd5;
   localparam logic [4:0] TextChars  = 5'd27;
   localparam logic [6:0] FragChars  = 7'd61;
   localparam logic [5:0] StartChars = 6'd11;
   localparam logic [5:0] TailChars  = 6'd32;
   localparam logic [3:0] HdrLast    = 4'd13;

   typedef enum logic [1:0] {
      CMD_START,
      CMD_CHAR,
      CMD_LAST
   } cmd_kind_type;

   // data holds the identity for a start, the 6-bit text code otherwise.
   typedef struct packed {
      cmd_kind_type kind;
      logic [29:0]  data;
   } cmd_type;

   function automatic logic [5:0] six_bit_code(input logic [7:0] c);
      logic [7:0] t;
      t = 8'd0;
      if (c >= "A" && c <= "Z") begin
         t = c - 8'd64;
      end else if (c >= "a" && c <= "z") begin
         t = c - 8'd96;
      end else if (c >= "0" && c <= "9") begin
         t = c;
      end
      return t[5:0];
   endfunction

   function automatic logic [7:0] armor(input logic [5:0] v);
      logic [7:0] c;
      c = {2'b00, v} + 8'd48;
      if (v > 6'd39) begin
         c = c + 8'd8;
      end
      return c;
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h37 + {4'h0, v});
   endfunction

   // Sentence header "!AIVDM,2,<frag>,,A," by position.
   function automatic logic [7:0] hdr_char(input logic [3:0] idx, input logic [7:0] frag);
      logic [7:0] c;
      c = ",";
      case (idx)
         4'd0:    c = "!";
         4'd1:    c = "A";
         4'd2:    c = "I";
         4'd3:    c = "V";
         4'd4:    c = "D";
         4'd5:    c = "M";
         4'd7:    c = "2";
         4'd9:    c = frag;
         4'd12:   c = "A";
         default: c = ",";
      endcase
      return c;
   endfunction

endpackage

/* hdl/aisenc_front.sv */
// Front part: accepts input words, tracks the open message and queues commands.
module aisenc_front
   import aisenc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        req_tuser,
   input  logic        q_full,
   output logic        cmd_push,
   output cmd_type     cmd
);

   localparam logic ModeStart = 1'b0;

   logic       open_ff, open_in;
   logic [4:0] pos_ff, pos_in;
   logic [4:0] pos_next;
   logic       accept;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;

   always_comb begin
      open_in   = open_ff;
      pos_in    = pos_ff;
      cmd_push  = 1'b0;
      cmd.kind  = CMD_START;
      cmd.data  = req_tdata[29:0];
      pos_next  = pos_ff + 5'd1;
      if (accept) begin
         if (req_tuser == ModeStart) begin
            cmd_push = 1'b1;
            open_in  = 1'b1;
            pos_in   = 5'd0;
         end else if (open_ff) begin
            // A text character with no message open is dropped.
            cmd_push = 1'b1;
            cmd.data = {24'd0, six_bit_code(req_tdata[37:30])};
            if (pos_next >= TextChars) begin
               cmd.kind = CMD_LAST;
               open_in  = 1'b0;
               pos_in   = 5'd0;
            end else begin
               cmd.kind = CMD_CHAR;
               pos_in   = pos_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         pos_ff  <= 5'd0;
      end else begin
         open_ff <= open_in;
         pos_ff  <= pos_in;
      end
   end

endmodule

/* hdl/aisenc_queue.sv */
// Short command queue between the front and back parts.
module aisenc_queue
   import aisenc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head_cmd,
   output logic    head_valid,
   output logic    full
);

   cmd_type                   entries_ff [QueueDepth];
   logic [QueuePtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCountBits-1:0] count_ff, count_in;
   logic                      do_push, do_pop;

   assign full       = (count_ff == QueueCountBits'(QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrBits'(QueueDepth - 1)) ? '0
                                                                  : wr_ptr_ff + QueuePtrBits'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrBits'(QueueDepth - 1)) ? '0
                                                                  : rd_ptr_ff + QueuePtrBits'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QueueCountBits'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QueueCountBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* hdl/aisenc_back.sv */
// Back part: byte sequencer that writes headers, armored payload and closing checksums.
module aisenc_back
   import aisenc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  logic       cmd_valid,
   output logic       cmd_pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tuser,
   output logic       rsp_tlast
);

   localparam logic [3:0] ClsComma = 4'd0;
   localparam logic [3:0] ClsFill  = 4'd1;
   localparam logic [3:0] ClsStar  = 4'd2;
   localparam logic [3:0] ClsHexHi = 4'd3;
   localparam logic [3:0] ClsHexLo = 4'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HDR,
      ST_PAY,
      ST_CLS
   } state_type;

   state_type   state_ff, state_in;
   logic [3:0]  idx_ff, idx_in;
   logic        frag2_ff, frag2_in;
   logic        final_ff, final_in;
   logic        last_cmd_ff, last_cmd_in;
   logic [5:0]  pay_left_ff, pay_left_in;
   logic [6:0]  chars_ff, chars_in;
   logic [7:0]  xor_ff, xor_in;
   logic [3:0]  left_ff, left_in;
   logic [65:0] shift_ff, shift_in;
   logic        valid_ff, valid_in;
   logic [7:0]  data_ff, data_in;
   logic        user_ff, user_in;
   logic        tlast_ff, tlast_in;

   logic        emit;
   logic        run_end;
   logic        sent_end;
   logic [7:0]  byte_val;
   logic [6:0]  chars_next;
   logic [5:0]  pay_left_next;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = tlast_ff;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      frag2_in      = frag2_ff;
      final_in      = final_ff;
      last_cmd_in   = last_cmd_ff;
      pay_left_in   = pay_left_ff;
      chars_in      = chars_ff;
      xor_in        = xor_ff;
      left_in       = left_ff;
      shift_in      = shift_ff;
      valid_in      = valid_ff && !rsp_tready;
      data_in       = data_ff;
      user_in       = user_ff;
      tlast_in      = tlast_ff;
      run_end       = 1'b0;
      sent_end      = 1'b0;
      byte_val      = 8'd0;
      chars_next    = chars_ff + 7'd1;
      pay_left_next = pay_left_ff - 6'd1;
      emit          = (state_ff != ST_IDLE) && (!valid_ff || rsp_tready);

      unique case (state_ff)
         ST_IDLE: byte_val = 8'd0;
         ST_HDR:  byte_val = hdr_char(idx_ff, frag2_ff ? "2" : "1");
         ST_PAY:  byte_val = armor(shift_ff[65:60]);
         ST_CLS: begin
            unique case (idx_ff)
               ClsComma: byte_val = ",";
               ClsFill:  byte_val = final_ff ? "2" : "0";
               ClsStar:  byte_val = "*";
               ClsHexHi: byte_val = hex_digit(xor_ff[7:4]);
               ClsHexLo: begin
                  byte_val = hex_digit(xor_ff[3:0]);
                  sent_end = 1'b1;
               end
               default:  byte_val = "*";
            endcase
         end
         default: byte_val = 8'd0;
      endcase

      if (emit) begin
         unique case (state_ff)
            ST_HDR: begin
               xor_in = (idx_ff == 4'd0) ? 8'd0 : (xor_ff ^ byte_val);
               if (idx_ff == HdrLast) begin
                  idx_in = 4'd0;
                  if (pay_left_ff != 6'd0) begin
                     state_in = ST_PAY;
                  end else if (last_cmd_ff) begin
                     state_in = ST_CLS;
                     final_in = 1'b1;
                  end else begin
                     state_in = ST_IDLE;
                     run_end  = 1'b1;
                  end
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
            ST_PAY: begin
               xor_in      = xor_ff ^ byte_val;
               chars_in    = chars_next;
               pay_left_in = pay_left_next;
               shift_in    = {shift_ff[59:0], 6'd0};
               if (chars_next == FragChars) begin
                  // First fragment is full: close it and open the second.
                  state_in = ST_CLS;
                  idx_in   = 4'd0;
                  final_in = 1'b0;
               end else if (pay_left_next == 6'd0) begin
                  if (last_cmd_ff) begin
                     state_in = ST_CLS;
                     idx_in   = 4'd0;
                     final_in = 1'b1;
                  end else begin
                     state_in = ST_IDLE;
                     run_end  = 1'b1;
                  end
               end
            end
            ST_CLS: begin
               if (idx_ff == ClsComma || idx_ff == ClsFill) begin
                  xor_in = xor_ff ^ byte_val;
               end
               if (idx_ff == ClsHexLo) begin
                  idx_in = 4'd0;
                  if (final_ff) begin
                     state_in = ST_IDLE;
                     run_end  = 1'b1;
                  end else begin
                     state_in = ST_HDR;
                     frag2_in = 1'b1;
                  end
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
            default: state_in = ST_IDLE;
         endcase
         valid_in = 1'b1;
         data_in  = byte_val;
         user_in  = sent_end;
         tlast_in = run_end;
      end

      // The next command loads while the last word of the current one goes out.
      cmd_pop = cmd_valid && ((state_ff == ST_IDLE) || (emit && run_end));
      if (cmd_pop) begin
         idx_in = 4'd0;
         unique case (cmd.kind)
            CMD_START: begin
               state_in    = ST_HDR;
               frag2_in    = 1'b0;
               final_in    = 1'b0;
               last_cmd_in = 1'b0;
               pay_left_in = StartChars;
               chars_in    = 7'd0;
               left_in     = 4'd0;
               shift_in    = {MsgType, 2'b00, cmd.data, 28'd0};
            end
            CMD_CHAR: begin
               state_in    = ST_PAY;
               last_cmd_in = 1'b0;
               pay_left_in = 6'd1;
               left_in     = cmd.data[3:0];
               shift_in    = {left_ff, cmd.data[5:4], 60'd0};
            end
            CMD_LAST: begin
               state_in    = ST_PAY;
               last_cmd_in = 1'b1;
               pay_left_in = TailChars;
               left_in     = 4'd0;
               shift_in    = {left_ff, cmd.data[5:0], 56'd0};
            end
            default: state_in = ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         idx_ff      <= 4'd0;
         frag2_ff    <= 1'b0;
         final_ff    <= 1'b0;
         last_cmd_ff <= 1'b0;
         pay_left_ff <= 6'd0;
         chars_ff    <= 7'd0;
         xor_ff      <= 8'd0;
         left_ff     <= 4'd0;
         shift_ff    <= '0;
         valid_ff    <= 1'b0;
         data_ff     <= 8'd0;
         user_ff     <= 1'b0;
         tlast_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         frag2_ff    <= frag2_in;
         final_ff    <= final_in;
         last_cmd_ff <= last_cmd_in;
         pay_left_ff <= pay_left_in;
         chars_ff    <= chars_in;
         xor_ff      <= xor_in;
         left_ff     <= left_in;
         shift_ff    <= shift_in;
         valid_ff    <= valid_in;
         data_ff     <= data_in;
         user_ff     <= user_in;
         tlast_ff    <= tlast_in;
      end
   end

endmodule

/* hdl/ais_type5_nmea_sentence_encoder_top.sv */
// Top level of the AIS type 5 encoder that writes two AIVDM sentences as a byte stream.
// A start word (tuser 0) carries the vessel identity and yields 25 bytes: the first
// sentence header and eleven armored payload characters. Exactly 27 text words (tuser 1)
// follow, 7 of call sign and 20 of name; each yields one byte, and the 27th yields 56:
// the rest of the payload, the close of the first sentence, the whole second sentence and
// its checksum. Text words with no message open are taken and dropped; a start word while
// a message is open abandons it. The input takes one word per cycle while the four-entry
// command queue has room, and the byte sequencer of the back part sends one byte per
// cycle while rsp_tready is high, so a long run at start or finish holds the input off
// once the queue is full. tlast marks the last byte that an input word causes; tuser marks
// the final checksum digit of each sentence.
module ais_type5_nmea_sentence_encoder_top
   import aisenc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // mmsi [29:0], char_code [37:30], zero [39:38]
   input  logic        req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte [7:0]
   output logic        rsp_tuser,   // sentence_end
   output logic        rsp_tlast
);

   cmd_type push_cmd;
   cmd_type head_cmd;
   logic    cmd_push;
   logic    cmd_pop;
   logic    head_valid;
   logic    q_full;

   aisenc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .cmd_push   (cmd_push),
      .cmd        (push_cmd)
   );

   aisenc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_cmd   (push_cmd),
      .pop        (cmd_pop),
      .head_cmd   (head_cmd),
      .head_valid (head_valid),
      .full       (q_full)
   );

   aisenc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd        (head_cmd),
      .cmd_valid  (head_valid),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* hdl/aisenc_checker.sv */
// Port checker for the AIS type 5 encoder and its binding to the top level.
module aisenc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser,
   input logic       rsp_tlast
);

   // No word is offered in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word offered straight after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   // A sentence ends on an uppercase hex digit of its checksum.
   a_end_is_hex: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         (rsp_tdata >= 8'h30 && rsp_tdata <= 8'h39) ||
         (rsp_tdata >= 8'h41 && rsp_tdata <= 8'h46))
      else $error("sentence end is not a hex digit");

   // A sentence start is never the last word of a run nor a sentence end.
   a_start_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata == 8'h21 |-> !rsp_tlast && !rsp_tuser)
      else $error("sentence start marked as last word");

endmodule

bind ais_type5_nmea_sentence_encoder_top aisenc_checker u_checker (.*);
